### rtl/core/dhcp_lease_table_top_assert.svh
// Assertion macros used by the lease table checker.
`ifndef DHCP_LEASE_TABLE_TOP_ASSERT_SVH
`define DHCP_LEASE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DLT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DLT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/dlt_pkg.sv
package dlt_pkg;

  localparam int POOL_SLOTS_DEF = 32;

  localparam int MODE_W  = 2;
  localparam int MAC_W   = 48;
  localparam int IP_W    = 32;
  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 5;
  localparam int COUNT_W = 6;

  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_SERVER_IP  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_POOL_START = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_POOL_COUNT = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_DISCOVER = 2'd0,
    MODE_REQUEST  = 2'd1,
    MODE_INFORM   = 2'd2,
    MODE_OTHER    = 2'd3
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_OFFER = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_NONE  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_RD,
    ST_CMP,
    ST_FREE,
    ST_BIND,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic prep;
    logic rd;
    logic cmp;
    logic free_wr;
    logic bind_wr;
    logic out_load;
  } dlt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_skip;
    logic scan_last;
    logic disc;
    logic out_busy;
  } dlt_sts_t;

  // last octet of a slot: start + i, plus one at and past the server octet
  function automatic logic [7:0] slot_octet(input logic [7:0] start,
                                            input logic [7:0] idx,
                                            input logic       skip,
                                            input logic [7:0] skip_at);
    logic bump;
    bump = skip && (idx >= skip_at);
    return start + idx + {7'd0, bump};
  endfunction

endpackage

### rtl/core/dlt_ram.sv
module dlt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/dlt_ctrl.sv
module dlt_ctrl
  import dlt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  dlt_sts_t sts,
  output logic     in_ready,
  output dlt_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        state_nxt = sts.scan_skip ? ST_DONE : ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (sts.scan_last) begin
          state_nxt = sts.disc ? ST_DONE : ST_FREE;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_FREE: begin
        state_nxt = ST_BIND;
      end
      ST_BIND: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // nothing is taken while reset is held
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = rst_n;
        cmd.load_item = in_valid && rst_n;
      end
      ST_PREP: cmd.prep     = 1'b1;
      ST_RD:   cmd.rd       = 1'b1;
      ST_CMP:  cmd.cmp      = 1'b1;
      ST_FREE: cmd.free_wr  = 1'b1;
      ST_BIND: cmd.bind_wr  = 1'b1;
      ST_DONE: cmd.out_load = !sts.out_busy;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### rtl/core/dlt_dp.sv
module dlt_dp
  import dlt_pkg::*;
#(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  dlt_cmd_t              cmd,
  output dlt_sts_t              sts,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser
);

  localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int CNT_W = $clog2(POOL_SLOTS + 1);

  // config
  logic [IP_W-1:0]    server_ip_r;
  logic [7:0]         pool_start_r;
  logic [COUNT_W-1:0] pool_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_ip_r  <= '0;
      pool_start_r <= '0;
      pool_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SERVER_IP:  server_ip_r  <= cfg_wdata;
        CFG_POOL_START: pool_start_r <= cfg_wdata[7:0];
        CFG_POOL_COUNT: pool_count_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // item
  mode_t           mode_r;
  logic [MAC_W-1:0] mac_r;
  logic [IP_W-1:0]  req_ip_r;
  logic             req_ok_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_r   <= mode_t'(in_tuser[1:0]);
      req_ok_r <= in_tuser[2];
      mac_r    <= in_tdata[MAC_W-1:0];
      req_ip_r <= in_tdata[MAC_W+IP_W-1:MAC_W];
    end
  end

  // pool layout
  logic [8:0]       cnt_lim, cnt_req, n0;
  logic [7:0]       skip_at_c;
  logic             skip_c;
  logic [CNT_W-1:0] n_c;

  always_comb begin
    cnt_lim   = 9'(POOL_SLOTS);
    cnt_req   = 9'(pool_count_r);
    n0        = (cnt_req > cnt_lim) ? cnt_lim : cnt_req;
    skip_at_c = server_ip_r[7:0] - pool_start_r;
    skip_c    = (9'(skip_at_c) < n0);
    n_c       = CNT_W'(n0 - 9'(skip_c));
  end

  logic [CNT_W-1:0] n_r;
  logic             skip_r;
  logic [7:0]       skip_at_r;
  logic [CNT_W-1:0] cnt_r;

  // scan bookkeeping
  logic             mac_hit_r, zero_hit_r, addr_hit_r, bind_ok_r;
  logic [IDX_W-1:0] mac_idx_r, zero_idx_r, addr_idx_r;
  logic [MAC_W-1:0] addr_mac_r;

  logic [POOL_SLOTS-1:0] valid_r;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [MAC_W-1:0]      ram_wdata;
  logic [MAC_W-1:0]      ram_rdata;
  logic [IDX_W-1:0]      slot;
  logic [MAC_W-1:0]      slot_mac;
  logic [7:0]            scan_octet;
  logic                  addr_eq;
  logic                  bind_go;

  dlt_ram #(
    .WIDTH(MAC_W),
    .DEPTH(POOL_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(slot),
    .rdata(ram_rdata)
  );

  always_comb begin
    slot       = cnt_r[IDX_W-1:0];
    slot_mac   = valid_r[slot] ? ram_rdata : '0;
    scan_octet = slot_octet(pool_start_r, 8'(cnt_r), skip_r, skip_at_r);
    addr_eq    = ({server_ip_r[31:8], scan_octet} == req_ip_r);
    // addressed slot is vacant if it read empty or is the client's own slot, freed before
    bind_go    = addr_hit_r &&
                 ((mac_hit_r && (mac_idx_r == addr_idx_r)) || (addr_mac_r == '0));
    ram_we     = (cmd.free_wr && mac_hit_r) || (cmd.bind_wr && bind_go);
    ram_waddr  = cmd.bind_wr ? addr_idx_r : mac_idx_r;
    ram_wdata  = cmd.bind_wr ? mac_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      mac_hit_r  <= 1'b0;
      zero_hit_r <= 1'b0;
      addr_hit_r <= 1'b0;
      bind_ok_r  <= 1'b0;
    end else begin
      if (cmd.prep) begin
        n_r        <= n_c;
        skip_r     <= skip_c;
        skip_at_r  <= skip_at_c;
        cnt_r      <= '0;
        mac_hit_r  <= 1'b0;
        zero_hit_r <= 1'b0;
        addr_hit_r <= 1'b0;
        bind_ok_r  <= 1'b0;
      end
      if (cmd.cmp) begin
        cnt_r <= cnt_r + 1'b1;
        if (!mac_hit_r && (slot_mac == mac_r)) begin
          mac_hit_r <= 1'b1;
          mac_idx_r <= slot;
        end
        if (!zero_hit_r && (slot_mac == '0)) begin
          zero_hit_r <= 1'b1;
          zero_idx_r <= slot;
        end
        if (!addr_hit_r && addr_eq) begin
          addr_hit_r <= 1'b1;
          addr_idx_r <= slot;
          addr_mac_r <= slot_mac;
        end
      end
      if (cmd.bind_wr && bind_go) begin
        bind_ok_r <= 1'b1;
      end
    end
  end

  // result
  kind_t            kind_c;
  logic [IDX_W-1:0] res_idx;
  logic [IP_W-1:0]  ip_c;
  logic [7:0]       res_octet;
  logic             out_valid_r;
  kind_t            out_kind_r;
  logic [IP_W-1:0]  out_ip_r;
  logic [SLOT_W-1:0] out_slot_r;

  always_comb begin
    kind_c  = KIND_NONE;
    res_idx = '0;
    priority if (mode_r == MODE_DISCOVER && mac_hit_r) begin
      kind_c  = KIND_OFFER;
      res_idx = mac_idx_r;
    end else if (mode_r == MODE_DISCOVER && zero_hit_r) begin
      kind_c  = KIND_OFFER;
      res_idx = zero_idx_r;
    end else if (mode_r != MODE_DISCOVER && bind_ok_r) begin
      kind_c  = KIND_ACK;
      res_idx = addr_idx_r;
    end else begin
      kind_c  = KIND_NONE;
    end
    res_octet = slot_octet(pool_start_r, 8'(res_idx), skip_r, skip_at_r);
    ip_c      = (kind_c == KIND_NONE) ? '0 : {server_ip_r[31:8], res_octet};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r <= kind_c;
      out_ip_r   <= ip_c;
      out_slot_r <= SLOT_W'(res_idx);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_slot_r, out_ip_r};
  assign out_tuser  = out_kind_r;

  always_comb begin
    sts.scan_skip = (mode_r == MODE_OTHER) ||
                    (mode_r == MODE_REQUEST && !req_ok_r) ||
                    (n_c == '0);
    sts.scan_last = ({1'b0, cnt_r} + 1'b1) >= {1'b0, n_r};
    sts.disc      = (mode_r == MODE_DISCOVER);
    sts.out_busy  = out_valid_r && !out_tready;
  end

endmodule

### rtl/core/dhcp_lease_table_top.sv
// Channel  | Ports                    | Contents (low bits first)
// ---------+--------------------------+-------------------------------------------
// in       | in_tvalid/tready/tdata/  | tdata: client_mac[47:0], requested_ip[79:48]
//          | tuser                    | tuser: mode[1:0], requested_ip_ok[2]
// out      | out_tvalid/tready/tdata/ | tdata: assigned_ip[31:0], slot_index[36:32]
//          | tuser                    | tuser: reply_kind[1:0]
// cfg      | cfg_we/addr/wdata        | 0 server_ip, 1 pool_start, 2 pool_count
//
// One request at a time. A request sets up the pool, then walks the slots
// (n active slots, one RAM read plus one compare per slot), then does a free
// and a bind write for request/inform, then loads the result.
// The registered read of the lease RAM sets the pace.
// Reset (rst_n low, synchronous) clears config and all slot valid bits at
// once: every slot reads vacant right after reset, no clearing pass.
// A finished result waits in the output register; the next request is
// taken meanwhile and only stalls at its own result load.
module dhcp_lease_table_top
  import dlt_pkg::*;
#(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // client_mac, requested_ip
  input  logic [IN_USER_W-1:0]  in_tuser,   // mode, requested_ip_ok
  // reply channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // assigned_ip, slot_index
  output logic [OUT_USER_W-1:0] out_tuser   // reply_kind
);

  dlt_cmd_t cmd;
  dlt_sts_t sts;

  // sequencer: idle, pool setup, read/compare per slot, free, bind, reply
  dlt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .sts     (sts),
    .in_ready(in_tready),
    .cmd     (cmd)
  );

  // config, lease RAM with valid bits, slot walk bookkeeping, reply register
  dlt_dp #(
    .POOL_SLOTS(POOL_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

### rtl/core/dlt_checker.sv
`include "dhcp_lease_table_top_assert.svh"

module dlt_checker
  import dlt_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_we,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,  // assigned_ip, slot_index
  input logic [OUT_USER_W-1:0] out_tuser   // reply_kind
);

  logic                             out_stall;
  logic [OUT_USER_W+OUT_DATA_W-1:0] out_word;
  logic                             kind_legal;
  logic                             none_valid;
  logic                             in_acc;

  assign out_stall  = out_tvalid && !out_tready;
  assign out_word   = {out_tuser, out_tdata};
  assign kind_legal = (out_tuser == KIND_OFFER) || (out_tuser == KIND_ACK) ||
                      (out_tuser == KIND_NONE);
  assign none_valid = out_tvalid && (out_tuser == KIND_NONE);
  assign in_acc     = in_tvalid && in_tready;

  // a stalled reply holds
  `DLT_ASSERT_NXT(a_out_hold, out_stall, out_tvalid && $stable(out_word), "stalled reply changed")

  // only offer, ack or no-reply codes
  `DLT_ASSERT_IMP(a_kind_legal, out_tvalid, kind_legal, "bad reply kind")

  // no reply carries zero address and slot
  `DLT_ASSERT_IMP(a_none_zero, none_valid, out_tdata == '0, "no-reply with nonzero payload")

  // one request in work at a time
  `DLT_ASSERT_NXT(a_one_item, in_acc, !in_tready, "request taken while busy")

  // config only changes while the block is quiet
  `DLT_ASSERT_IMP(a_cfg_quiet, cfg_we, in_tready && !out_tvalid, "config write while busy")

endmodule

bind dhcp_lease_table_top dlt_checker u_dlt_checker (.*);
